@@ hdl/imu_tilt_and_rate_scaler_unit_assert.svh @@
// Assertion macros used by the top-level pipeline file
`ifndef IMU_TILT_AND_RATE_SCALER_UNIT_ASSERT_SVH
`define IMU_TILT_AND_RATE_SCALER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define ITR_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define ITR_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

@@ hdl/itr_pkg.sv @@
`default_nettype none
package itr_pkg;
	localparam int MAX_STEPS = 24;
	localparam int XW = 40; // cordic x/y/z width
	typedef enum logic [1:0] {
		REG_ACCEL_GAIN = 2'd0,
		REG_GYRO_GAIN  = 2'd1,
		REG_Z_OFFSET   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [16:0] wx;
		logic signed [16:0] wy;
		logic signed [16:0] wz;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] gz;
	} scaled_t;

	function automatic logic signed [39:0] atan_q16(input int i);
		logic signed [39:0] t [MAX_STEPS];
		t = '{40'sd2949120, 40'sd1740967, 40'sd919879, 40'sd466945, 40'sd234379,
			40'sd117265, 40'sd58666, 40'sd29335, 40'sd14668, 40'sd7334, 40'sd3667,
			40'sd1833, 40'sd917, 40'sd458, 40'sd229, 40'sd115, 40'sd57, 40'sd29,
			40'sd14, 40'sd7, 40'sd4, 40'sd2, 40'sd1, 40'sd0};
		return t[i];
	endfunction
endpackage
`default_nettype wire

@@ hdl/itr_scale.sv @@
`default_nettype none
// Two-stage scaling: multiply, then round, negate, offset and saturate.
module itr_scale import itr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [17:0]        accel_gain,
	input  wire logic [17:0]        gyro_gain,
	input  wire logic signed [15:0] z_offset,
	input  wire logic signed [15:0] r [6],
	output scaled_t                 res
);
	logic signed [34:0] prod_s1 [6];
	logic signed [15:0] g_s1 [3];
	logic signed [15:0] zoff_s1;
	scaled_t res_s2;
	logic signed [35:0] rd [6];
	logic signed [35:0] v [6];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= r[i] * $signed({1'b0, accel_gain});
				prod_s1[i+3] <= r[i+3] * $signed({1'b0, gyro_gain});
				g_s1[i] <= r[i+3];
			end
			zoff_s1 <= z_offset;
		end
	end

	always_comb begin
		for (int i = 0; i < 6; i++)
			rd[i] = (36'(prod_s1[i]) + 36'sd32768) >>> 16;
		v[0] = -rd[0];
		v[1] = rd[1];
		v[2] = rd[2] - 36'(zoff_s1);
		v[3] = rd[3];
		v[4] = -rd[4];
		v[5] = -rd[5];
	end

	function automatic logic signed [15:0] sat16(input logic signed [35:0] x);
		return x > 36'sd32767 ? 16'sh7fff : (x < -36'sd32768 ? 16'sh8000 : x[15:0]);
	endfunction
	function automatic logic signed [16:0] sat17(input logic signed [35:0] x);
		return x > 36'sd65535 ? 17'sh0ffff : (x < -36'sd65536 ? 17'sh10000 : x[16:0]);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.ax <= sat16(v[0]);
			res_s2.ay <= sat16(v[1]);
			res_s2.az <= sat16(v[2]);
			res_s2.wx <= sat17(v[3]);
			res_s2.wy <= sat17(v[4]);
			res_s2.wz <= sat17(v[5]);
			res_s2.gx <= g_s1[0];
			res_s2.gy <= g_s1[1];
			res_s2.gz <= g_s1[2];
		end
	end
	assign res = res_s2;
endmodule
`default_nettype wire

@@ hdl/itr_tilt.sv @@
`default_nettype none
// Pipelined tilt: square sum, bit-serial-stage root (2 bits per stage), CORDIC, round.
// Every stage advances only when en is high.
module itr_tilt import itr_pkg::*; #(
	parameter int STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [16:0] num,
	input  wire logic signed [15:0] a,
	input  wire logic signed [15:0] b,
	output logic signed [15:0]      angle
);
	localparam int NS = STEPS < 1 ? 1 : (STEPS > MAX_STEPS ? MAX_STEPS : STEPS);
	localparam int RS = 24; // root stages: 48-bit radicand, 2 bits each

	logic [31:0] aa_s1, bb_s1;
	logic signed [16:0] n_s1, n_s2;
	logic [47:0] sq_s2;
	logic [47:0] rv_s [RS+1];
	logic [47:0] rr_s [RS+1];
	logic signed [16:0] rn_s [RS+1];
	logic signed [XW-1:0] cx [NS+1], cy [NS+1], cz [NS+1];
	logic signed [XW-1:0] zr;

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s1 <= 32'(a * a);
			bb_s1 <= 32'(b * b);
			n_s1 <= num;
			sq_s2 <= {15'd0, {1'b0, aa_s1} + {1'b0, bb_s1}} << 16;
			n_s2 <= n_s1;
		end
	end

	// Non-restoring-free digit recurrence: one 2-bit digit per stage.
	always_comb begin
		rv_s[0] = sq_s2;
		rr_s[0] = '0;
		rn_s[0] = n_s2;
	end
	for (genvar k = 0; k < RS; k++) begin : g_root
		localparam logic [47:0] BIT = 48'd1 << (46 - 2 * k);
		logic [47:0] v_n, r_n;
		always_comb begin
			if (rv_s[k] >= rr_s[k] + BIT) begin
				v_n = rv_s[k] - (rr_s[k] + BIT);
				r_n = (rr_s[k] >> 1) + BIT;
			end else begin
				v_n = rv_s[k];
				r_n = rr_s[k] >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rv_s[k+1] <= v_n;
				rr_s[k+1] <= r_n;
				rn_s[k+1] <= rn_s[k];
			end
		end
	end

	always_comb begin
		cx[0] = XW'($signed({1'b0, rr_s[RS][23:0]}));
		cy[0] = XW'(rn_s[RS]) <<< 8;
		cz[0] = '0;
	end
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [XW-1:0] dx, dy;
		always_comb begin
			dx = cy[i] >>> i;
			dy = cx[i] >>> i;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy[i] > 0) begin
					cx[i+1] <= cx[i] + dx;
					cy[i+1] <= cy[i] - dy;
					cz[i+1] <= cz[i] + atan_q16(i);
				end else if (cy[i] < 0) begin
					cx[i+1] <= cx[i] - dx;
					cy[i+1] <= cy[i] + dy;
					cz[i+1] <= cz[i] - atan_q16(i);
				end else begin
					cx[i+1] <= cx[i];
					cy[i+1] <= cy[i];
					cz[i+1] <= cz[i];
				end
			end
		end
	end

	assign zr = (cz[NS] + XW'(128)) >>> 8;
	always_ff @(posedge clk) begin
		if (en)
			angle <= zr > XW'(23040) ? 16'sd23040 :
				(zr < -XW'(23040) ? -16'sd23040 : zr[15:0]);
	end
endmodule
`default_nettype wire

@@ hdl/imu_tilt_and_rate_scaler_unit.sv @@
`default_nettype none
// Channel  | Direction | Contents
// s_axis   | in        | tdata: raw_accel_x..z, raw_gyro_x..z (16b each)
// m_axis   | out       | tdata: scaled accel, rates, raw gyro, roll, pitch
// cfg      | in        | cfg_we, cfg_index, cfg_data (18b)
//
// One item per cycle unless the output stalls; 2 (scaling) + 2 (squares) + 24
// (root) + CORDIC_STEPS (one stage each) + 1 (round) + 1 (output) register
// stages, the first loaded at the accepting edge.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset clears valid bits and the registers to their defaults.
module imu_tilt_and_rate_scaler_unit import itr_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
	input  wire logic [95:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// accel_x_g, accel_y_g, accel_z_g, rate_x, rate_y, rate_z, gyro_x_out,
	// gyro_y_out, gyro_z_out, roll_deg, pitch_deg, zero fill to 184 bits
	output logic [183:0]      m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [17:0]  cfg_data
);
	`include "imu_tilt_and_rate_scaler_unit_assert.svh"

	localparam int NS = CORDIC_STEPS < 1 ? 1 :
		(CORDIC_STEPS > MAX_STEPS ? MAX_STEPS : CORDIC_STEPS);
	localparam int LAT = 2 + 2 + 24 + NS + 1; // scale + tilt stages

	logic [17:0] accel_gain_q, gyro_gain_q;
	logic signed [15:0] z_offset_q;
	logic [LAT-1:0] vld_q;
	logic en;
	logic signed [15:0] r [6];
	scaled_t sc;
	scaled_t dl_s [NS+28];
	logic signed [15:0] roll, pitch;

	// Hold every stage when the last item waits and cannot leave.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_gain_q <= 18'd65536;
			gyro_gain_q <= 18'd71535;
			z_offset_q <= 16'sd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEL_GAIN: accel_gain_q <= cfg_data;
				REG_GYRO_GAIN:  gyro_gain_q <= cfg_data;
				REG_Z_OFFSET:   z_offset_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb
		for (int i = 0; i < 6; i++)
			r[i] = s_axis_tdata[16*i +: 16];

	itr_scale u_scale (
		.clk(clk), .en(en),
		.accel_gain(accel_gain_q), .gyro_gain(gyro_gain_q), .z_offset(z_offset_q),
		.r(r), .res(sc)
	);

	// Widen the numerator so negating full-scale x stays positive.
	itr_tilt #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en),
		.num(17'(sc.ay)), .a(sc.ax), .b(sc.az), .angle(roll)
	);
	itr_tilt #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en),
		.num(-(17'(sc.ax))), .a(sc.ay), .b(sc.az), .angle(pitch)
	);

	// Delay the scaled values alongside the tilt pipeline.
	assign dl_s[0] = sc;
	for (genvar k = 0; k < NS + 27; k++) begin : g_dl
		always_ff @(posedge clk)
			if (en) dl_s[k+1] <= dl_s[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
			m_axis_tvalid <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			m_axis_tdata <= {5'd0, pitch, roll, dl_s[NS+27].gz, dl_s[NS+27].gy,
				dl_s[NS+27].gx, dl_s[NS+27].wz, dl_s[NS+27].wy, dl_s[NS+27].wx,
				dl_s[NS+27].az, dl_s[NS+27].ay, dl_s[NS+27].ax};
	end

	`ITR_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ITR_ASSERT_IMPL(a_rdy, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`ITR_ASSERT_NEXT(a_adv, clk, arst_n, s_axis_tvalid && s_axis_tready, vld_q[0])
endmodule
`default_nettype wire
